// ===== src/assert_macros.svh =====
// Assertion macros shared by the sorted priority queue RTL.
// Included by every module that carries concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== src/spq_pkg.sv =====
// Package for the sorted priority queue: field widths, codes and the cell control word.
// No dependencies; used by spq_cell and sorted_priority_queue_top.
`default_nettype none
package spq_pkg;

  localparam int VAL_W = 32;
  localparam int PRI_W = 32;
  localparam int ST_W  = 2;

  // Request codes.
  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  // Status codes.
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

  // Head value reported for an empty queue.
  localparam logic [VAL_W-1:0] EMPTY_HEAD = 32'h8000_0000;

  // Operation broadcast to every cell of the chain.
  typedef struct packed {
    logic push;
    logic pop;
  } spq_ctl_t;

endpackage
`default_nettype wire

// ===== src/sorted_priority_queue_top.sv =====
// Top level of the sorted priority queue: a chain of DEPTH cells plus the fill counter.
// Depends on spq_pkg, spq_cell and assert_macros.svh.
`default_nettype none
// A request (push or pop) is taken at any edge where start is high and busy is low; busy
// is high only while reset is held, so one request per cycle is sustained. Each request
// gives one result word in the next cycle, shown for exactly one cycle with out_strobe high;
// the receiver cannot stall it.
// The result describes the queue after the request: head value (0x80000000 when empty),
// empty flag, fill count and status (ok, push dropped because full, pop on empty).
// The result is ready then because of the cell chain, where every cell compares its priority
// with the new word and shifts or inserts in the same cycle.
`include "assert_macros.svh"
module sorted_priority_queue_top
  import spq_pkg::*;
#(
  parameter int DEPTH = 16,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic                    in_req_type,
  input  wire logic [VAL_W-1:0]        in_item_value,
  input  wire logic signed [PRI_W-1:0] in_item_priority,
  output logic                         out_strobe,
  output logic [VAL_W-1:0]             out_head_value,
  output logic                         out_is_empty,
  output logic [CNT_W-1:0]             out_fill_count,
  output logic [ST_W-1:0]              out_status
);

  logic                    accept;
  logic                    full;
  logic                    empty;
  spq_ctl_t                ctl;
  logic [CNT_W-1:0]        count_r;
  logic [CNT_W-1:0]        count_nxt;
  logic [ST_W-1:0]         status_nxt;
  logic                    after_a [DEPTH];
  logic [VAL_W-1:0]        val_a   [DEPTH];
  logic signed [PRI_W-1:0] pri_a   [DEPTH];
  logic [VAL_W-1:0]        valn_a  [DEPTH];

  // No request is taken while reset is held.
  assign busy   = !rst_n;
  assign accept = start && !busy;
  assign full   = (count_r == CNT_W'(DEPTH));
  assign empty  = (count_r == '0);

  // Decode the request into the word broadcast along the chain.
  always_comb begin
    ctl.push   = accept && (in_req_type == REQ_PUSH) && !full;
    ctl.pop    = accept && (in_req_type == REQ_POP) && !empty;
    count_nxt  = count_r;
    status_nxt = ST_OK;
    if (ctl.push) begin
      count_nxt = count_r + 1'b1;
    end else if (ctl.pop) begin
      count_nxt = count_r - 1'b1;
    end
    if (in_req_type == REQ_PUSH && full) begin
      status_nxt = ST_FULL;
    end else if (in_req_type == REQ_POP && empty) begin
      status_nxt = ST_EMPTY;
    end
  end

  // The chain of cells; cell 0 is the head.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                    prev_after;
    logic [VAL_W-1:0]        prev_val;
    logic signed [PRI_W-1:0] prev_pri;
    logic [VAL_W-1:0]        next_val;
    logic signed [PRI_W-1:0] next_pri;

    if (i == 0) begin : g_first
      assign prev_after = 1'b1;
      assign prev_val   = '0;
      assign prev_pri   = '0;
    end else begin : g_mid
      assign prev_after = after_a[i-1];
      assign prev_val   = val_a[i-1];
      assign prev_pri   = pri_a[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_val = '0;
      assign next_pri = '0;
    end else begin : g_inner
      assign next_val = val_a[i+1];
      assign next_pri = pri_a[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .valid      (CNT_W'(i) < count_r),
      .new_pri    (in_item_priority),
      .new_val    (in_item_value),
      .prev_after (prev_after),
      .prev_val   (prev_val),
      .prev_pri   (prev_pri),
      .next_val   (next_val),
      .next_pri   (next_pri),
      .after      (after_a[i]),
      .val_r      (val_a[i]),
      .pri_r      (pri_a[i]),
      .val_nxt    (valn_a[i])
    );
  end

  // Fill counter and result strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      out_strobe <= 1'b0;
    end else begin
      count_r    <= count_nxt;
      out_strobe <= accept;
    end
  end

  // Result word describing the queue after the request.
  always_ff @(posedge clk) begin
    out_head_value <= (count_nxt == '0) ? EMPTY_HEAD : valn_a[0];
    out_is_empty   <= (count_nxt == '0);
    out_fill_count <= count_nxt;
    out_status     <= status_nxt;
  end

  `ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_r <= CNT_W'(DEPTH))
  `ASSERT_NEXT(a_strobe_follows, clk, rst_n, accept, out_strobe)
  `ASSERT_IMPL(a_empty_flag, clk, rst_n, out_strobe, out_is_empty == (out_fill_count == '0))
  `ASSERT_IMPL(a_full_status, clk, rst_n, out_strobe && (out_status == ST_FULL),
               out_fill_count == CNT_W'(DEPTH))
  `ASSERT_IMPL(a_pop_empty, clk, rst_n, out_strobe && (out_status == ST_EMPTY),
               out_is_empty && (out_head_value == EMPTY_HEAD))

endmodule
`default_nettype wire

// ===== src/spq_cell.sv =====
// One storage cell of the sorted chain: holds a value/priority pair and shifts or inserts.
// Depends on spq_pkg.
`default_nettype none
module spq_cell
  import spq_pkg::*;
(
  input  wire logic                    clk,
  input  wire spq_ctl_t                ctl,
  input  wire logic                    valid,
  input  wire logic signed [PRI_W-1:0] new_pri,
  input  wire logic [VAL_W-1:0]        new_val,
  input  wire logic                    prev_after,
  input  wire logic [VAL_W-1:0]        prev_val,
  input  wire logic signed [PRI_W-1:0] prev_pri,
  input  wire logic [VAL_W-1:0]        next_val,
  input  wire logic signed [PRI_W-1:0] next_pri,
  output logic                         after,
  output logic [VAL_W-1:0]             val_r,
  output logic signed [PRI_W-1:0]      pri_r,
  output logic [VAL_W-1:0]             val_nxt
);

  logic signed [PRI_W-1:0] pri_nxt;

  // The held word stays ahead of a new word of equal or larger priority number.
  assign after = valid && (pri_r <= new_pri);

  // Push keeps, inserts or takes the left neighbor; pop takes the right neighbor.
  always_comb begin
    val_nxt = val_r;
    pri_nxt = pri_r;
    if (ctl.push && !after) begin
      if (prev_after) begin
        val_nxt = new_val;
        pri_nxt = new_pri;
      end else begin
        val_nxt = prev_val;
        pri_nxt = prev_pri;
      end
    end else if (ctl.pop) begin
      val_nxt = next_val;
      pri_nxt = next_pri;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    pri_r <= pri_nxt;
  end

endmodule
`default_nettype wire
